// ----- sv/fwrl_pkg.sv -----
package fwrl_pkg;

    // table geometry
    localparam int SLOTS  = 4;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // field widths
    localparam int ID_W   = 64;
    localparam int TIME_W = 32;
    localparam int MIN_W  = 17;
    localparam int CNT_W  = 16;
    localparam int OUT_SLOT_W = 2;

    // minute derivation: floor(now * RECIP / 2^RECIP_SHIFT) is the quotient or one short
    localparam int unsigned MS_PER_MIN = 60000;
    localparam logic [TIME_W-1:0] RECIP = 32'd2345624805;
    localparam int RECIP_SHIFT = 47;
    localparam int PROD_W = 2 * TIME_W;

    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // status of the minute divider
    typedef struct packed {
        logic             done;
        logic [MIN_W-1:0] minute;
    } t_div_stat;

endpackage

// ----- sv/fwrl_minute_div.sv -----
module fwrl_minute_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fwrl_pkg::TIME_W-1:0]   i_now_ms,
    output fwrl_pkg::t_div_stat           o_stat
);

    logic [fwrl_pkg::PROD_W-1:0]  r_prod;
    logic [fwrl_pkg::TIME_W-1:0]  r_now;
    logic                         r_s1;
    logic                         r_done;
    logic [fwrl_pkg::MIN_W-1:0]   r_minute;

    logic [fwrl_pkg::MIN_W-1:0]   q_est;
    logic [fwrl_pkg::TIME_W:0]    q_back;
    logic [fwrl_pkg::TIME_W:0]    rem_full;
    logic [fwrl_pkg::MIN_W-1:0]   rem;
    logic [fwrl_pkg::MIN_W-1:0]   q_fix;

    // second step: remainder check corrects an estimate that is one short
    always_comb begin
        q_est    = r_prod[fwrl_pkg::RECIP_SHIFT +: fwrl_pkg::MIN_W];
        q_back   = (fwrl_pkg::TIME_W+1)'(q_est) * (fwrl_pkg::TIME_W+1)'(fwrl_pkg::MS_PER_MIN);
        rem_full = (fwrl_pkg::TIME_W+1)'(r_now) - q_back;
        rem      = rem_full[fwrl_pkg::MIN_W-1:0];
        q_fix    = (rem >= fwrl_pkg::MIN_W'(fwrl_pkg::MS_PER_MIN)) ?
                   q_est + fwrl_pkg::MIN_W'(1) : q_est;
    end

    // first step: reciprocal multiply; the corrected minute of the second step is registered here too
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= fwrl_pkg::PROD_W'(i_now_ms) * fwrl_pkg::PROD_W'(fwrl_pkg::RECIP);
            r_now  <= i_now_ms;
        end
        if (r_s1) begin
            r_minute <= q_fix;
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_s1   <= 1'b1;
            r_done <= 1'b0;
        end else if (r_s1) begin
            r_s1   <= 1'b0;
            r_done <= 1'b1;
        end
    end

    assign o_stat.done   = r_done;
    assign o_stat.minute = r_minute;

endmodule

// ----- sv/per_user_fixed_window_rate_limiter_unit.sv -----
// Per-user fixed-window rate limiter. Each request carries a user id and a
// millisecond time; the unit keeps a small table of user slots, each with the
// minute of its last request and a saturating count of requests in that
// minute, and answers whether the request stays within the configured limit.
// An unknown id claims the lowest free slot; with the table full it is counted
// in slot 0. A request passes through an accept step, a walk of the table in
// which a single shared 64-bit comparator checks one slot per step, and an
// update step that loads the result. A hit in slot k stops the walk there.
// The result is valid from the cycle after the update, which is also the
// first cycle in which the next request can be accepted. The minute number
// comes from a two-step reciprocal divider that runs alongside the scan and
// is ready by the earliest update. The unit stalls input while a request is
// in work; the update also waits while an earlier result is stalled and has
// not yet been taken. The limit register may be written at any cycle and is
// read only in the update cycle.
module per_user_fixed_window_rate_limiter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [fwrl_pkg::ID_W-1:0]   i_user_id,
    input  logic [fwrl_pkg::TIME_W-1:0]        i_now_ms,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_allowed,
    output logic [fwrl_pkg::OUT_SLOT_W-1:0]    o_slot_used,
    output logic [fwrl_pkg::CNT_W-1:0]         o_request_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fwrl_pkg::CNT_W-1:0]         i_cfg_limit_per_minute
);

    fwrl_pkg::t_state r_state, n_state;

    logic [fwrl_pkg::ID_W-1:0]     r_id, n_id;
    logic [fwrl_pkg::SLOT_W-1:0]   r_idx, n_idx;
    logic                          r_hit, n_hit;
    logic [fwrl_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic                          r_free_found, n_free_found;
    logic [fwrl_pkg::SLOT_W-1:0]   r_free, n_free;

    logic [fwrl_pkg::ID_W-1:0]     r_owner  [fwrl_pkg::SLOTS];
    logic [fwrl_pkg::MIN_W-1:0]    r_minute [fwrl_pkg::SLOTS];
    logic [fwrl_pkg::CNT_W-1:0]    r_count  [fwrl_pkg::SLOTS];

    logic [fwrl_pkg::CNT_W-1:0]    r_limit;

    logic                          r_out_valid, n_out_valid;
    logic                          r_allowed, n_allowed;
    logic [fwrl_pkg::OUT_SLOT_W-1:0] r_slot_used, n_slot_used;
    logic [fwrl_pkg::CNT_W-1:0]    r_req_count, n_req_count;

    logic                          in_acc;
    logic                          out_free;
    logic                          load;
    logic                          claim;
    logic [fwrl_pkg::SLOT_W-1:0]   upd_slot;
    logic [fwrl_pkg::SLOT_W-1:0]   rd_addr;
    logic [fwrl_pkg::ID_W-1:0]     owner_rd;
    logic [fwrl_pkg::MIN_W-1:0]    minute_rd;
    logic [fwrl_pkg::CNT_W-1:0]    count_rd;
    logic                          id_match;
    logic                          is_free;
    logic [fwrl_pkg::CNT_W-1:0]    base_count;
    logic [fwrl_pkg::CNT_W-1:0]    new_count;
    fwrl_pkg::t_div_stat           div_stat;

    // minute number of the request time
    fwrl_minute_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc),
        .i_now_ms (i_now_ms),
        .o_stat   (div_stat)
    );

    // table read port and shared comparator
    always_comb begin
        upd_slot  = r_hit ? r_slot : (r_free_found ? r_free : '0);
        rd_addr   = (r_state == fwrl_pkg::ST_SCAN) ? r_idx : upd_slot;
        owner_rd  = r_owner[rd_addr];
        minute_rd = r_minute[rd_addr];
        count_rd  = r_count[rd_addr];
        id_match  = (owner_rd == r_id);
        is_free   = (owner_rd == '0);
        base_count = (minute_rd != div_stat.minute) ? '0 : count_rd;
        new_count  = (base_count == fwrl_pkg::COUNT_MAX) ?
                     base_count : base_count + fwrl_pkg::CNT_W'(1);
    end

    // sequencer next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_id         = r_id;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_free_found = r_free_found;
        n_free       = r_free;
        in_acc       = 1'b0;
        load         = 1'b0;
        claim        = 1'b0;
        out_free     = !r_out_valid || !i_out_stall;
        case (r_state)
            fwrl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    in_acc       = 1'b1;
                    n_state      = fwrl_pkg::ST_SCAN;
                    n_id         = i_user_id;
                    n_idx        = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            fwrl_pkg::ST_SCAN: begin
                if (id_match) begin
                    n_hit   = 1'b1;
                    n_slot  = r_idx;
                    n_state = fwrl_pkg::ST_UPDATE;
                end else begin
                    if (is_free && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free       = r_idx;
                    end
                    if (r_idx == fwrl_pkg::SLOT_W'(fwrl_pkg::SLOTS - 1)) begin
                        n_state = fwrl_pkg::ST_UPDATE;
                    end else begin
                        n_idx = r_idx + fwrl_pkg::SLOT_W'(1);
                    end
                end
            end
            fwrl_pkg::ST_UPDATE: begin
                if (div_stat.done && out_free) begin
                    load    = 1'b1;
                    claim   = !r_hit && r_free_found;
                    n_state = fwrl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fwrl_pkg::ST_IDLE;
            end
        endcase

        // result register
        n_allowed   = r_allowed;
        n_slot_used = r_slot_used;
        n_req_count = r_req_count;
        if (load) begin
            n_out_valid = 1'b1;
            n_allowed   = (new_count <= r_limit);
            n_slot_used = fwrl_pkg::OUT_SLOT_W'(upd_slot);
            n_req_count = new_count;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwrl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_limit      <= fwrl_pkg::LIMIT_RESET;
        end else begin
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_limit_per_minute;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_id        <= n_id;
        r_slot      <= n_slot;
        r_free      <= n_free;
        r_allowed   <= n_allowed;
        r_slot_used <= n_slot_used;
        r_req_count <= n_req_count;
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fwrl_pkg::SLOTS; i++) begin
                r_owner[i]  <= '0;
                r_minute[i] <= '0;
                r_count[i]  <= '0;
            end
        end else if (load) begin
            r_minute[upd_slot] <= div_stat.minute;
            r_count[upd_slot]  <= new_count;
            if (claim) begin
                r_owner[upd_slot] <= r_id;
            end
        end
    end

    assign o_in_stall      = (r_state != fwrl_pkg::ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_allowed       = r_allowed;
    assign o_slot_used     = r_slot_used;
    assign o_request_count = r_req_count;
    assign o_cfg_ready     = 1'b1;

endmodule

// ----- sv/fwrl_checker.sv -----
module fwrl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic                             o_allowed,
    input logic [fwrl_pkg::OUT_SLOT_W-1:0]  o_slot_used,
    input logic [fwrl_pkg::CNT_W-1:0]       o_request_count
);

    // one request at a time: input stalls right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a request");

    // a result needs at least the scan cycle before it appears
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after accept");

    // every counted request leaves a nonzero count
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_request_count != '0))
        else $error("result with zero request count");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_allowed) && $stable(o_slot_used)
             && $stable(o_request_count)))
        else $error("stalled result changed");

endmodule

bind per_user_fixed_window_rate_limiter_unit fwrl_checker u_fwrl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_allowed       (o_allowed),
    .o_slot_used     (o_slot_used),
    .o_request_count (o_request_count)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 120;

    // owners that end up in slots 0..3 after the directed part
    localparam logic signed [fwrl_pkg::ID_W-1:0] ID_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [fwrl_pkg::ID_W-1:0] ID_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [fwrl_pkg::ID_W-1:0] ID_ONES = -64'sd1;
    localparam logic signed [fwrl_pkg::ID_W-1:0] ID_MIX  = 64'sh5A5A_0000_C3C3_0001;

    typedef struct {
        logic                            allowed;
        logic [fwrl_pkg::OUT_SLOT_W-1:0] slot;
        logic [fwrl_pkg::CNT_W-1:0]      count;
    } t_verdict;

    // predicts the verdict of each accepted request and checks the block's answers
    class limiter_board;
        logic [fwrl_pkg::ID_W-1:0]  owner [fwrl_pkg::SLOTS];
        logic [fwrl_pkg::MIN_W-1:0] minute [fwrl_pkg::SLOTS];
        logic [fwrl_pkg::CNT_W-1:0] count [fwrl_pkg::SLOTS];
        logic [fwrl_pkg::CNT_W-1:0] limit;
        t_verdict                   expected_verdicts[$];
        int                         errors;

        function new();
            for (int i = 0; i < fwrl_pkg::SLOTS; i++) begin
                owner[i]  = '0;
                minute[i] = '0;
                count[i]  = '0;
            end
            limit  = fwrl_pkg::LIMIT_RESET;
            errors = 0;
        endfunction

        function void set_limit(logic [fwrl_pkg::CNT_W-1:0] value);
            limit = value;
        endfunction

        function int outstanding();
            return expected_verdicts.size();
        endfunction

        function void note_request(logic [fwrl_pkg::ID_W-1:0] id,
                                   logic [fwrl_pkg::TIME_W-1:0] now);
            int                         hit;
            logic [fwrl_pkg::MIN_W-1:0] cur_min;
            t_verdict                   v;
            cur_min = fwrl_pkg::MIN_W'(now / fwrl_pkg::MS_PER_MIN);
            hit = -1;
            // owned slot first, then the lowest free slot, else slot 0
            for (int i = 0; i < fwrl_pkg::SLOTS; i++) begin
                if (hit < 0 && owner[i] == id) hit = i;
            end
            if (hit < 0) begin
                for (int i = 0; i < fwrl_pkg::SLOTS; i++) begin
                    if (hit < 0 && owner[i] == '0) begin
                        hit = i;
                        owner[i] = id;
                    end
                end
            end
            if (hit < 0) hit = 0;
            // new minute window restarts the count
            if (minute[hit] != cur_min) begin
                minute[hit] = cur_min;
                count[hit]  = '0;
            end
            if (count[hit] != fwrl_pkg::COUNT_MAX) count[hit] = count[hit] + 1'b1;
            v.allowed = (count[hit] <= limit);
            v.slot    = fwrl_pkg::OUT_SLOT_W'(hit);
            v.count   = count[hit];
            expected_verdicts.push_back(v);
        endfunction

        function void check_result(logic allowed, logic [fwrl_pkg::OUT_SLOT_W-1:0] slot,
                                   logic [fwrl_pkg::CNT_W-1:0] cnt);
            t_verdict want;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                $display("%0t: (allowed %0d slot %0d count %0d)",
                         $time, allowed, slot, cnt);
                errors++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (want.allowed !== allowed) begin
                $display("%0t: allowed mismatch, expected %0d, actual %0d",
                         $time, want.allowed, allowed);
                errors++;
            end
            if (want.slot !== slot) begin
                $display("%0t: slot_used mismatch, expected %0d, actual %0d",
                         $time, want.slot, slot);
                errors++;
            end
            if (want.count !== cnt) begin
                $display("%0t: request_count mismatch, expected %0d, actual %0d",
                         $time, want.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic signed [fwrl_pkg::ID_W-1:0]  i_user_id;
    logic [fwrl_pkg::TIME_W-1:0]       i_now_ms;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic                              o_allowed;
    logic [fwrl_pkg::OUT_SLOT_W-1:0]   o_slot_used;
    logic [fwrl_pkg::CNT_W-1:0]        o_request_count;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [fwrl_pkg::CNT_W-1:0]        i_cfg_limit_per_minute;

    limiter_board                      board;
    logic signed [fwrl_pkg::ID_W-1:0]  owners [fwrl_pkg::SLOTS];
    logic [fwrl_pkg::TIME_W-1:0]       time_base;
    bit                                calm;
    int                                stall_left;
    int                                idle_cycles;
    int                                total_errors;

    per_user_fixed_window_rate_limiter_unit u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_user_id              (i_user_id),
        .i_now_ms               (i_now_ms),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_allowed              (o_allowed),
        .o_slot_used            (o_slot_used),
        .o_request_count        (o_request_count),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_limit_per_minute (i_cfg_limit_per_minute)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // handshake monitor and watchdog
    always @(posedge i_clk) begin
        idle_cycles = idle_cycles + 1;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                board.set_limit(i_cfg_limit_per_minute);
                idle_cycles = 0;
            end
            if (i_in_valid && !o_in_stall) begin
                board.note_request(i_user_id, i_now_ms);
                idle_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_result(o_allowed, o_slot_used, o_request_count);
                stall_left = calm ? 0 : $urandom_range(0, 8);
                idle_cycles = 0;
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result-side stall, drawn per result
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // drive one request after a random gap and wait until it is taken
    task automatic send_request(input logic signed [fwrl_pkg::ID_W-1:0] id,
                                input logic [fwrl_pkg::TIME_W-1:0] now);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_user_id  <= id;
        i_now_ms   <= now;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.outstanding() > 0) @(posedge i_clk);
    endtask

    // limit write, only with the block idle
    task automatic write_limit(input logic [fwrl_pkg::CNT_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid            <= 1'b1;
        i_cfg_limit_per_minute <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hand-picked requests: id zero, slot claiming, full table, window edges
    task automatic run_directed();
        // id zero counts in a free slot without claiming it
        send_request('0, 32'd0);
        send_request('0, 32'd0);
        // claiming slot 0 inherits the count left by id zero
        send_request(ID_MIN, 32'd59999);
        send_request(ID_MAX, 32'd60000);
        send_request(ID_MAX, 32'd60000);
        send_request('0, 32'd120000);
        send_request(ID_ONES, 32'hFFFF_FFFF);
        send_request('0, 32'hFFFF_FFFF);
        send_request(ID_MIX, 32'd5);
        // table full: id zero and unknown ids fall back to slot 0
        send_request('0, 32'd59999);
        send_request(64'sd42, 32'd1000);
        send_request(ID_MIN, 32'd0);
        // limit reached exactly, then exceeded
        write_limit(16'd2);
        send_request(ID_MIX, 32'd10);
        send_request(ID_MIX, 32'd20);
        send_request(ID_MIX, 32'd30);
        write_limit(16'd0);
        send_request(ID_MAX, 32'd60001);
        send_request(ID_ONES, 32'd4_294_900_000);
        write_limit(fwrl_pkg::COUNT_MAX);
        send_request(ID_MIN, 32'd30000);
        send_request(ID_MAX, 32'd119999);
    endtask

    // bursts of requests from a mostly known user set with a drifting clock
    task automatic run_random(input int n);
        int                               k;
        int                               burst;
        int                               pick;
        logic signed [fwrl_pkg::ID_W-1:0] id;
        logic [fwrl_pkg::TIME_W-1:0]      now;
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 15) == 0) calm = ~calm;
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : 1;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                id = owners[fwrl_pkg::SLOT_W'($urandom_range(0, fwrl_pkg::SLOTS - 1))];
            else if (pick == 6)
                id = '0;
            else if (pick == 7)
                id = $signed({$urandom, $urandom});
            else
                id = fwrl_pkg::ID_W'($urandom_range(1, 6));
            repeat (burst) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    time_base = $urandom;
                else
                    time_base = time_base + $urandom_range(0, 2500);
                now = (pick == 1) ? $urandom : time_base;
                send_request(id, now);
                k++;
            end
        end
    endtask

    // main sequence
    initial begin
        logic [fwrl_pkg::CNT_W-1:0] phase_limits [12];
        board                  = new();
        owners[0]              = ID_MIN;
        owners[1]              = ID_MAX;
        owners[2]              = ID_ONES;
        owners[3]              = ID_MIX;
        time_base              = 32'd0;
        calm                   = 1'b0;
        stall_left             = 0;
        idle_cycles            = 0;
        i_rst_n                = 1'b0;
        i_in_valid             = 1'b0;
        i_user_id              = '0;
        i_now_ms               = '0;
        i_out_stall            = 1'b0;
        i_cfg_valid            = 1'b0;
        i_cfg_limit_per_minute = '0;

        phase_limits = '{16'd0, fwrl_pkg::COUNT_MAX, 16'd1, 16'd3, 16'd5, 16'd2,
                         16'd8, 16'd4, 16'd7, 16'd6, 16'd0, 16'd3};
        phase_limits[6] = fwrl_pkg::CNT_W'($urandom_range(0, 12));
        phase_limits[9] = fwrl_pkg::CNT_W'($urandom);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // random phases, each under its own limit
        for (int p = 0; p < 12; p++) begin
            write_limit(phase_limits[p]);
            run_random(PHASE_ITEMS);
        end

        drain();
        repeat (fwrl_pkg::SLOTS + 4) @(posedge i_clk);

        total_errors = board.errors + board.outstanding();
        if (total_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
